FILE: design/line_triangle_intersect_defines.svh
// Assertion macros shared by the line-triangle intersection design.
`ifndef LINE_TRIANGLE_INTERSECT_DEFINES_SVH
`define LINE_TRIANGLE_INTERSECT_DEFINES_SVH
`define LTI_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define LTI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

FILE: design/lti_pkg.sv
// Package with shared constants and types for the line-triangle intersection block.
package lti_pkg;
	localparam int unsigned CoordWidth = 24;
	localparam int unsigned TagWidth = 16;
	localparam int unsigned NumRegs = 6;
	localparam int unsigned AddrWidth = 5;

	typedef enum logic [2:0] {
		REG_START_X = 3'd0,
		REG_START_Y = 3'd1,
		REG_START_Z = 3'd2,
		REG_END_X = 3'd3,
		REG_END_Y = 3'd4,
		REG_END_Z = 3'd5
	} reg_idx_t;
endpackage

FILE: design/lti_divider.sv
// Pipelined signed restoring divider, one quotient bit per stage.
module lti_divider #(
	parameter int unsigned NW = 80,
	parameter int unsigned DW = 80,
	parameter int unsigned QW = 24,
	parameter int unsigned SW = 1
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic signed [NW-1:0]  num,
	input  logic signed [DW-1:0]  den,
	input  logic [SW-1:0]         side_in,
	output logic signed [QW-1:0]  quo,
	output logic [SW-1:0]         side_out
);
	localparam int unsigned QB = QW + 1;
	localparam int unsigned RW = DW + 1;

	logic [NW-1:0] n_mag;
	logic [DW-1:0] d_mag;
	logic          neg;
	logic [RW-1:0] rem_q [QB+1];
	logic [NW-1:0] nsh_q [QB+1];
	logic [DW-1:0] dv_q [QB+1];
	logic [QB-1:0] qt_q [QB+1];
	logic          ng_q [QB+1];
	logic [SW-1:0] sd_q [QB+1];
	logic [QB-1:0] qres;

	always_comb begin
		neg = num[NW-1] ^ den[DW-1];
		n_mag = num[NW-1] ? NW'(-num) : NW'(num);
		d_mag = den[DW-1] ? DW'(-den) : DW'(den);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= RW'(n_mag >> QB);
			nsh_q[0] <= n_mag << (NW - QB);
			dv_q[0] <= d_mag;
			qt_q[0] <= '0;
			ng_q[0] <= neg;
			sd_q[0] <= side_in;
		end
	end

	for (genvar i = 0; i < QB; i++) begin : g_stage
		logic [RW-1:0] tr;
		logic [RW:0]   df;
		always_comb begin
			tr = {rem_q[i][RW-2:0], nsh_q[i][NW-1]};
			df = {1'b0, tr} - {2'b00, dv_q[i]};
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[i+1] <= df[RW] ? tr : df[RW-1:0];
				nsh_q[i+1] <= nsh_q[i] << 1;
				dv_q[i+1] <= dv_q[i];
				qt_q[i+1] <= {qt_q[i][QB-2:0], ~df[RW]};
				ng_q[i+1] <= ng_q[i];
				sd_q[i+1] <= sd_q[i];
			end
		end
	end

	assign qres = ng_q[QB] ? QB'(-qt_q[QB]) : qt_q[QB];
	assign quo = qres[QW-1:0];
	assign side_out = sd_q[QB];
endmodule

FILE: design/lti_volumes.sv
// Front pipeline: differences, cross products, triple products, weighted sums.
module lti_volumes #(
	parameter int unsigned CW = lti_pkg::CoordWidth,
	parameter int unsigned TW = lti_pkg::TagWidth
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic signed [CW-1:0]  p [3],
	input  logic signed [CW-1:0]  q [3],
	input  logic signed [CW-1:0]  va [3],
	input  logic signed [CW-1:0]  vb [3],
	input  logic signed [CW-1:0]  vc [3],
	input  logic [TW-1:0]         tag,
	output logic                  hit,
	output logic signed [4*CW+7:0] num [3],
	output logic signed [3*CW+5:0] den,
	output logic [TW-1:0]         tag_out
);
	localparam int unsigned DWD = CW + 1;
	localparam int unsigned PW = 2 * DWD + 1;
	localparam int unsigned LB = DWD + 1;
	localparam int unsigned LPW = DWD + LB + 1;
	localparam int unsigned HPW = DWD + PW - LB;
	localparam int unsigned VW = 3 * DWD + 3;
	localparam int unsigned CK = VW / 3;
	localparam int unsigned PPW = CK + 1 + CW;
	localparam int unsigned SW2 = 3 * CW + 6;
	localparam int unsigned NMW = 4 * CW + 8;

	logic signed [DWD-1:0] pq_s1 [3], pa_s1 [3], pb_s1 [3], pc_s1 [3];
	logic signed [CW-1:0]  a_s1 [3], b_s1 [3], c_s1 [3];
	logic [TW-1:0]         tag_s1, tag_s2, tag_s3, tag_s4, tag_s5, tag_s6, tag_s7, tag_s8;
	logic signed [PW-1:0]  m_s2 [3], n_s2 [3];
	logic signed [DWD-1:0] pq_s2 [3], pa_s2 [3], pb_s2 [3];
	logic signed [CW-1:0]  a_s2 [3], b_s2 [3], c_s2 [3];
	logic signed [LPW-1:0] ub_lo_s3 [3], va_lo_s3 [3], wq_lo_s3 [3];
	logic signed [HPW-1:0] ub_hi_s3 [3], va_hi_s3 [3], wq_hi_s3 [3];
	logic signed [CW-1:0]  a_s3 [3], b_s3 [3], c_s3 [3];
	logic signed [VW-1:0]  ut_s4 [3], vt_s4 [3], wt_s4 [3];
	logic signed [CW-1:0]  a_s4 [3], b_s4 [3], c_s4 [3];
	logic signed [VW-1:0]  u_s5, v_s5, w_s5;
	logic signed [CW-1:0]  a_s5 [3], b_s5 [3], c_s5 [3];
	logic signed [PPW-1:0] ua_p_s6 [3][3], vb_p_s6 [3][3], wc_p_s6 [3][3];
	logic signed [SW2-1:0] den_s6, den_s7, den_s8;
	logic                  hit_s6, hit_s7, hit_s8;
	logic signed [NMW-1:0] ua_s7 [3], vb_s7 [3], wc_s7 [3];
	logic signed [NMW-1:0] num_s8 [3];
	logic                  su_p, su_n, sv_p, sv_n, sw_p, sw_n, hit_c;

	// Slice j of a volume; the top slice carries the sign, the lower ones are unsigned.
	function automatic logic signed [CK:0] chunk_of(input logic signed [VW-1:0] x, input int j);
		logic top;
		top = (j == 2) ? x[VW-1] : 1'b0;
		return {top, x[j*CK +: CK]};
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				pq_s1[k] <= DWD'(q[k]) - DWD'(p[k]);
				pa_s1[k] <= DWD'(va[k]) - DWD'(p[k]);
				pb_s1[k] <= DWD'(vb[k]) - DWD'(p[k]);
				pc_s1[k] <= DWD'(vc[k]) - DWD'(p[k]);
			end
			a_s1 <= va;
			b_s1 <= vb;
			c_s1 <= vc;
			tag_s1 <= tag;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s2[0] <= PW'(pq_s1[1] * pc_s1[2]) - PW'(pq_s1[2] * pc_s1[1]);
			m_s2[1] <= PW'(pq_s1[2] * pc_s1[0]) - PW'(pq_s1[0] * pc_s1[2]);
			m_s2[2] <= PW'(pq_s1[0] * pc_s1[1]) - PW'(pq_s1[1] * pc_s1[0]);
			n_s2[0] <= PW'(pb_s1[1] * pa_s1[2]) - PW'(pb_s1[2] * pa_s1[1]);
			n_s2[1] <= PW'(pb_s1[2] * pa_s1[0]) - PW'(pb_s1[0] * pa_s1[2]);
			n_s2[2] <= PW'(pb_s1[0] * pa_s1[1]) - PW'(pb_s1[1] * pa_s1[0]);
			pq_s2 <= pq_s1;
			pa_s2 <= pa_s1;
			pb_s2 <= pb_s1;
			a_s2 <= a_s1;
			b_s2 <= b_s1;
			c_s2 <= c_s1;
			tag_s2 <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				ub_lo_s3[k] <= LPW'(pb_s2[k] * $signed({1'b0, m_s2[k][LB-1:0]}));
				ub_hi_s3[k] <= HPW'(pb_s2[k] * $signed(m_s2[k][PW-1:LB]));
				va_lo_s3[k] <= LPW'(pa_s2[k] * $signed({1'b0, m_s2[k][LB-1:0]}));
				va_hi_s3[k] <= HPW'(pa_s2[k] * $signed(m_s2[k][PW-1:LB]));
				wq_lo_s3[k] <= LPW'(pq_s2[k] * $signed({1'b0, n_s2[k][LB-1:0]}));
				wq_hi_s3[k] <= HPW'(pq_s2[k] * $signed(n_s2[k][PW-1:LB]));
			end
			a_s3 <= a_s2;
			b_s3 <= b_s2;
			c_s3 <= c_s2;
			tag_s3 <= tag_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				ut_s4[k] <= (VW'(ub_hi_s3[k]) <<< LB) + VW'(ub_lo_s3[k]);
				vt_s4[k] <= (VW'(va_hi_s3[k]) <<< LB) + VW'(va_lo_s3[k]);
				wt_s4[k] <= (VW'(wq_hi_s3[k]) <<< LB) + VW'(wq_lo_s3[k]);
			end
			a_s4 <= a_s3;
			b_s4 <= b_s3;
			c_s4 <= c_s3;
			tag_s4 <= tag_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s5 <= ut_s4[0] + ut_s4[1] + ut_s4[2];
			v_s5 <= -(vt_s4[0] + vt_s4[1] + vt_s4[2]);
			w_s5 <= wt_s4[0] + wt_s4[1] + wt_s4[2];
			a_s5 <= a_s4;
			b_s5 <= b_s4;
			c_s5 <= c_s4;
			tag_s5 <= tag_s4;
		end
	end

	always_comb begin
		su_n = u_s5[VW-1];
		sv_n = v_s5[VW-1];
		sw_n = w_s5[VW-1];
		su_p = !su_n && (u_s5 != '0);
		sv_p = !sv_n && (v_s5 != '0);
		sw_p = !sw_n && (w_s5 != '0);
		hit_c = !((su_p || sv_p || sw_p) && (su_n || sv_n || sw_n))
			&& (su_p || sv_p || sw_p || su_n || sv_n || sw_n);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				for (int j = 0; j < 3; j++) begin
					ua_p_s6[k][j] <= PPW'(chunk_of(u_s5, j) * a_s5[k]);
					vb_p_s6[k][j] <= PPW'(chunk_of(v_s5, j) * b_s5[k]);
					wc_p_s6[k][j] <= PPW'(chunk_of(w_s5, j) * c_s5[k]);
				end
			end
			den_s6 <= SW2'(u_s5) + SW2'(v_s5) + SW2'(w_s5);
			hit_s6 <= hit_c;
			tag_s6 <= tag_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				ua_s7[k] <= (NMW'(ua_p_s6[k][2]) <<< (2*CK)) + (NMW'(ua_p_s6[k][1]) <<< CK)
					+ NMW'(ua_p_s6[k][0]);
				vb_s7[k] <= (NMW'(vb_p_s6[k][2]) <<< (2*CK)) + (NMW'(vb_p_s6[k][1]) <<< CK)
					+ NMW'(vb_p_s6[k][0]);
				wc_s7[k] <= (NMW'(wc_p_s6[k][2]) <<< (2*CK)) + (NMW'(wc_p_s6[k][1]) <<< CK)
					+ NMW'(wc_p_s6[k][0]);
			end
			den_s7 <= den_s6;
			hit_s7 <= hit_s6;
			tag_s7 <= tag_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				num_s8[k] <= ua_s7[k] + vb_s7[k] + wc_s7[k];
			end
			den_s8 <= hit_s7 ? den_s7 : SW2'(1);
			hit_s8 <= hit_s7;
			tag_s8 <= tag_s7;
		end
	end

	assign num = num_s8;
	assign den = den_s8;
	assign hit = hit_s8;
	assign tag_out = tag_s8;
endmodule

FILE: design/line_triangle_intersect.sv
// Between a triangle beat and its result beat lie 8 volume stages, COORD_WIDTH+2 divider stages
// and one output register.
// Throughput: one triangle beat per cycle; the whole pipeline advances when its tail is free.
// The divider's one-quotient-bit-per-stage chain sets most of the latency.
// Reset clears the line registers and all valid bits; data registers are not reset.
// A stall holds every stage in place, so no beat is lost or repeated.
module line_triangle_intersect #(
	parameter int unsigned COORD_WIDTH = lti_pkg::CoordWidth
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [lti_pkg::AddrWidth-1:0]     paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, triangle_tag, zero fill
	input  logic [((9*COORD_WIDTH+16+7)/8)*8-1:0] s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// point_x, point_y, point_z, result_tag, zero fill
	output logic [((3*COORD_WIDTH+16+7)/8)*8-1:0] m_axis_tdata,
	// hit
	output logic                              m_axis_tuser
);
	localparam int unsigned CW = COORD_WIDTH;
	localparam int unsigned TW = lti_pkg::TagWidth;
	localparam int unsigned DEPTH = 8 + CW + 2 + 1;
	localparam int unsigned OW = ((3*CW+16+7)/8)*8;

	logic signed [CW-1:0] reg_q [lti_pkg::NumRegs];
	logic signed [CW-1:0] p [3], q [3], va [3], vb [3], vc [3];
	logic [TW-1:0] tag, tag_v;
	logic en, hit_v;
	logic [DEPTH-1:0] vld_q;
	logic signed [4*CW+7:0] num [3];
	logic signed [3*CW+5:0] den;
	logic signed [CW-1:0] quo [3];
	logic [TW:0] side [3];
	logic cfg_we;
	lti_pkg::reg_idx_t widx;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;
	assign widx = lti_pkg::reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lti_pkg::NumRegs; i++) reg_q[i] <= '0;
		end else if (cfg_we && paddr[1:0] == 2'b00) begin
			unique case (widx)
				lti_pkg::REG_START_X: reg_q[0] <= pwdata[CW-1:0];
				lti_pkg::REG_START_Y: reg_q[1] <= pwdata[CW-1:0];
				lti_pkg::REG_START_Z: reg_q[2] <= pwdata[CW-1:0];
				lti_pkg::REG_END_X: reg_q[3] <= pwdata[CW-1:0];
				lti_pkg::REG_END_Y: reg_q[4] <= pwdata[CW-1:0];
				lti_pkg::REG_END_Z: reg_q[5] <= pwdata[CW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[1:0] == 2'b00) begin
			unique case (widx)
				lti_pkg::REG_START_X: prdata = 32'(reg_q[0]);
				lti_pkg::REG_START_Y: prdata = 32'(reg_q[1]);
				lti_pkg::REG_START_Z: prdata = 32'(reg_q[2]);
				lti_pkg::REG_END_X: prdata = 32'(reg_q[3]);
				lti_pkg::REG_END_Y: prdata = 32'(reg_q[4]);
				lti_pkg::REG_END_Z: prdata = 32'(reg_q[5]);
				default: prdata = '0;
			endcase
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			p[k] = reg_q[k];
			q[k] = reg_q[3+k];
			va[k] = s_axis_tdata[k*CW +: CW];
			vb[k] = s_axis_tdata[(3+k)*CW +: CW];
			vc[k] = s_axis_tdata[(6+k)*CW +: CW];
		end
		tag = s_axis_tdata[9*CW +: TW];
	end

	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_q[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DEPTH-2:0], s_axis_tvalid};
		end
	end

	lti_volumes #(.CW(CW), .TW(TW)) u_vol (
		.clk(clk), .en(en), .p(p), .q(q), .va(va), .vb(vb), .vc(vc), .tag(tag),
		.hit(hit_v), .num(num), .den(den), .tag_out(tag_v)
	);

	for (genvar k = 0; k < 3; k++) begin : g_div
		lti_divider #(.NW(4*CW+8), .DW(3*CW+6), .QW(CW), .SW(TW+1)) u_div (
			.clk(clk), .en(en), .num(num[k]), .den(den),
			.side_in({hit_v, tag_v}), .quo(quo[k]), .side_out(side[k])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_axis_tuser <= side[0][TW];
			m_axis_tdata <= OW'({side[0][TW-1:0],
				side[0][TW] ? quo[2] : CW'(0),
				side[0][TW] ? quo[1] : CW'(0),
				side[0][TW] ? quo[0] : CW'(0)});
		end
	end

	`include "line_triangle_intersect_defines.svh"

	`LTI_ASSERT_NEXT(a_stall_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "output beat dropped during stall")
	`LTI_ASSERT_IMPL(a_ready_free, clk, arst_n, !m_axis_tvalid, s_axis_tready, "input blocked with empty output")
	`LTI_ASSERT_IMPL(a_nohit_zero, clk, arst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[3*CW-1:0] == '0, "miss with nonzero point")
endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the line-triangle intersection stream block.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW = lti_pkg::CoordWidth;
	localparam int SW = ((9*CW+16+7)/8)*8;
	localparam int MW = ((3*CW+16+7)/8)*8;
	localparam int LATENCY = 8 + CW + 2 + 1;
	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;
	localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

	typedef struct packed {
		logic [15:0] tag;
		logic [8:0][CW-1:0] v;
	} triangle_t;

	typedef struct packed {
		logic hit;
		logic [CW-1:0] px;
		logic [CW-1:0] py;
		logic [CW-1:0] pz;
		logic [15:0] tag;
	} crossing_t;

	typedef struct packed {
		triangle_t shape;
		logic known;
		crossing_t want;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [lti_pkg::AddrWidth-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic s_axis_tvalid, s_axis_tready;
	logic [SW-1:0] s_axis_tdata;
	logic m_axis_tvalid, m_axis_tready;
	logic [MW-1:0] m_axis_tdata;
	logic m_axis_tuser;

	logic signed [CW-1:0] line_reg [6];
	crossing_t crossings_due [$];
	int errors = 0;
	int tri_count = 0;
	int hit_count = 0;
	int result_count = 0;
	int stall_cycles = 0;
	bit quiet = 0;
	bit hold_req = 0;

	line_triangle_intersect u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	function automatic int sign_of(logic signed [255:0] x);
		if (x < 0) return -1;
		if (x > 0) return 1;
		return 0;
	endfunction

	function automatic bit opposed(int s, int t);
		return (s > 0 && t < 0) || (s < 0 && t > 0);
	endfunction

	function automatic crossing_t line_crossing(triangle_t t);
		logic signed [255:0] pq [3], pa [3], pb [3], pc [3], m [3], n [3];
		logic signed [255:0] u, v, w, den, num, q;
		logic signed [255:0] ax, bx, cx, px;
		crossing_t r;
		int su, sv, sw;
		r = '0;
		r.tag = t.tag;
		for (int k = 0; k < 3; k++) begin
			px = line_reg[k];
			ax = $signed(t.v[k]);
			bx = $signed(t.v[3+k]);
			cx = $signed(t.v[6+k]);
			pq[k] = line_reg[3+k] - px;
			pa[k] = ax - px;
			pb[k] = bx - px;
			pc[k] = cx - px;
		end
		m[0] = pq[1]*pc[2] - pq[2]*pc[1];
		m[1] = pq[2]*pc[0] - pq[0]*pc[2];
		m[2] = pq[0]*pc[1] - pq[1]*pc[0];
		n[0] = pb[1]*pa[2] - pb[2]*pa[1];
		n[1] = pb[2]*pa[0] - pb[0]*pa[2];
		n[2] = pb[0]*pa[1] - pb[1]*pa[0];
		u = pb[0]*m[0] + pb[1]*m[1] + pb[2]*m[2];
		v = -(pa[0]*m[0] + pa[1]*m[1] + pa[2]*m[2]);
		w = pq[0]*n[0] + pq[1]*n[1] + pq[2]*n[2];
		su = sign_of(u);
		sv = sign_of(v);
		sw = sign_of(w);
		if (opposed(su, sv) || opposed(su, sw) || opposed(sv, sw)) return r;
		if (su == 0 && sv == 0 && sw == 0) return r;
		den = u + v + w;
		if (den == 0) return r;
		r.hit = 1'b1;
		for (int k = 0; k < 3; k++) begin
			ax = $signed(t.v[k]);
			bx = $signed(t.v[3+k]);
			cx = $signed(t.v[6+k]);
			num = u*ax + v*bx + w*cx;
			q = num / den;
			if (k == 0) r.px = q[CW-1:0];
			else if (k == 1) r.py = q[CW-1:0];
			else r.pz = q[CW-1:0];
		end
		return r;
	endfunction

	function automatic logic [CW-1:0] clamp(longint x);
		if (x > longint'(CMAX)) return CMAX;
		if (x < longint'(CMIN)) return CMIN;
		return x[CW-1:0];
	endfunction

	function automatic longint rnd_signed(longint amp);
		return longint'($urandom_range(0, 2*amp)) - amp;
	endfunction

	function automatic logic [CW-1:0] rnd_coord();
		return CW'($urandom());
	endfunction

	function automatic triangle_t make_tri(longint ax, longint ay, longint az, longint bx,
			longint by, longint bz, longint cx, longint cy, longint cz, int tag);
		triangle_t t;
		t.v[0] = clamp(ax); t.v[1] = clamp(ay); t.v[2] = clamp(az);
		t.v[3] = clamp(bx); t.v[4] = clamp(by); t.v[5] = clamp(bz);
		t.v[6] = clamp(cx); t.v[7] = clamp(cy); t.v[8] = clamp(cz);
		t.tag = tag[15:0];
		return t;
	endfunction

	// A triangle whose centroid lies near the line, so most of these cross it.
	function automatic triangle_t around_line(longint amp);
		longint x [3], d1, d2, fr;
		triangle_t t;
		fr = $urandom_range(0, 1024);
		for (int k = 0; k < 3; k++) begin
			x[k] = longint'(line_reg[k]) +
				((longint'(line_reg[3+k]) - longint'(line_reg[k])) * fr) / 1024;
			d1 = rnd_signed(amp);
			d2 = rnd_signed(amp);
			t.v[k] = clamp(x[k] + d1);
			t.v[3+k] = clamp(x[k] + d2);
			t.v[6+k] = clamp(x[k] - d1 - d2 + rnd_signed(amp / 8 + 1));
		end
		t.tag = 16'($urandom());
		return t;
	endfunction

	task automatic apb_write(input int idx, input logic [CW-1:0] value);
		@(negedge clk);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= lti_pkg::AddrWidth'(4*idx);
		pwdata <= {{(32-CW){value[CW-1]}}, value};
		@(negedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		if (idx < lti_pkg::NumRegs) line_reg[idx] = value;
	endtask

	task automatic apb_check(input int idx);
		@(negedge clk);
		psel <= 1; penable <= 0; pwrite <= 0;
		paddr <= lti_pkg::AddrWidth'(4*idx);
		@(negedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		if (prdata[CW-1:0] !== line_reg[idx]) begin
			errors++;
			$display("%0t register %0d read: expected %h actual %h", $time, idx,
				line_reg[idx], prdata[CW-1:0]);
		end
		@(negedge clk);
		psel <= 0; penable <= 0;
	endtask

	task automatic set_line(input logic [CW-1:0] sx, sy, sz, ex, ey, ez);
		wait (crossings_due.size() == 0);
		repeat (LATENCY + 4) @(posedge clk);
		apb_write(lti_pkg::REG_START_X, sx);
		apb_write(lti_pkg::REG_START_Y, sy);
		apb_write(lti_pkg::REG_START_Z, sz);
		apb_write(lti_pkg::REG_END_X, ex);
		apb_write(lti_pkg::REG_END_Y, ey);
		apb_write(lti_pkg::REG_END_Z, ez);
		for (int i = 0; i < lti_pkg::NumRegs; i++) apb_check(i);
	endtask

	// Holds tvalid across back-to-back beats; it only drops during an idle burst.
	task automatic send_tri(input triangle_t t, input logic known, input crossing_t want);
		logic [SW-1:0] d;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		d = '0;
		d[9*CW-1:0] = t.v;
		d[9*CW +: 16] = t.tag;
		s_axis_tvalid <= 1;
		s_axis_tdata <= d;
		do @(posedge clk); while (!s_axis_tready);
		crossings_due.push_back(known ? want : line_crossing(t));
		tri_count++;
		@(negedge clk);
	endtask

	task automatic end_burst();
		s_axis_tvalid <= 0;
	endtask

	task automatic random_phase(input int count, input longint amp, input int pressure_at);
		triangle_t t;
		for (int i = 0; i < count; i++) begin
			if (i == pressure_at) hold_req = 1;
			if ($urandom_range(0, 9) < 7) t = around_line(amp);
			else begin
				for (int k = 0; k < 9; k++) t.v[k] = rnd_coord();
				t.tag = 16'($urandom());
			end
			send_tri(t, 1'b0, '0);
		end
		end_burst();
	endtask

	initial begin
		m_axis_tready = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 0;
				m_axis_tready <= 0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 0;
				repeat ($urandom_range(1, 10) - 1) @(negedge clk);
			end else begin
				m_axis_tready <= 1;
			end
		end
	end

	always @(posedge clk) begin
		crossing_t got, want;
		if (m_axis_tvalid && m_axis_tready) begin
			got.hit = m_axis_tuser;
			got.px = m_axis_tdata[0 +: CW];
			got.py = m_axis_tdata[CW +: CW];
			got.pz = m_axis_tdata[2*CW +: CW];
			got.tag = m_axis_tdata[3*CW +: 16];
			result_count++;
			if (crossings_due.size() == 0) begin
				errors++;
				$display("%0t unexpected result beat: actual %h", $time, got);
			end else begin
				want = crossings_due.pop_front();
				if (got.hit) hit_count++;
				if (got.hit !== want.hit) begin
					errors++;
					$display("%0t hit: expected %b actual %b", $time, want.hit, got.hit);
				end
				if (got.px !== want.px) begin
					errors++;
					$display("%0t point_x: expected %h actual %h", $time, want.px, got.px);
				end
				if (got.py !== want.py) begin
					errors++;
					$display("%0t point_y: expected %h actual %h", $time, want.py, got.py);
				end
				if (got.pz !== want.pz) begin
					errors++;
					$display("%0t point_z: expected %h actual %h", $time, want.pz, got.pz);
				end
				if (got.tag !== want.tag) begin
					errors++;
					$display("%0t result_tag: expected %h actual %h", $time, want.tag,
						got.tag);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel
				|| !arst_n)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Timeout after %0d cycles without a beat.", stall_cycles);
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		stim_row_t rows [$];
		stim_row_t r;
		crossing_t miss;
		longint s;
		arst_n = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		s_axis_tvalid = 0; s_axis_tdata = '0;
		for (int i = 0; i < lti_pkg::NumRegs; i++) line_reg[i] = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// After reset the line is degenerate, so nothing is hit.
		s = 256;
		miss = '0;
		r.known = 1;
		r.shape = make_tri(-s, -s, 0, s, -s, 0, 0, s, 0, 16'h0000);
		r.want = miss; r.want.tag = 16'h0000; rows.push_back(r);
		r.shape = make_tri(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0, CMAX, CMIN, 16'hFFFF);
		r.want = miss; r.want.tag = 16'hFFFF; rows.push_back(r);
		foreach (rows[i]) send_tri(rows[i].shape, rows[i].known, rows[i].want);
		end_burst();

		set_line(0, 0, -10*s, 0, 0, 10*s);
		rows.delete();
		r.shape = make_tri(-s, -s, 0, s, -s, 0, 0, s, 0, 16'h1234);
		r.want = '0; r.want.hit = 1; r.want.tag = 16'h1234; rows.push_back(r);
		r.shape = make_tri(9*s, -s, 0, 11*s, -s, 0, 10*s, s, 0, 16'h00A5);
		r.want = miss; r.want.tag = 16'h00A5; rows.push_back(r);
		r.shape = make_tri(0, -s, -s, 0, s, -s, 0, 0, s, 16'h5A5A);
		r.want = miss; r.want.tag = 16'h5A5A; rows.push_back(r);
		r.shape = make_tri(7, 7, 7, 7, 7, 7, 7, 7, 7, 16'hC3C3);
		r.want = miss; r.want.tag = 16'hC3C3; rows.push_back(r);
		r.known = 0;
		r.shape = make_tri(0, 0, 3*s, 2*s, 0, s, 0, 2*s, -s, 16'h0001); rows.push_back(r);
		r.shape = make_tri(-s, 0, s, s, 0, s, 0, 2*s, s, 16'h0002); rows.push_back(r);
		r.shape = make_tri(s, 0, 0, -s, -s, s, -s, s, -s, 16'h0003); rows.push_back(r);
		r.shape = make_tri(CMIN, CMIN, CMIN, CMAX, CMIN, CMAX, 0, CMAX, 0, 16'h8000);
		rows.push_back(r);
		r.shape = make_tri(CMAX, CMAX, CMAX, CMIN, CMAX, CMIN, CMIN, CMIN, 1, 16'h7FFF);
		rows.push_back(r);
		r.shape = make_tri(CMIN, 0, 0, CMAX, CMIN, 0, CMAX, CMAX, 0, 16'hFFFF);
		rows.push_back(r);
		r.shape = make_tri(-1, -1, 5, 1, -1, -5, 0, 1, 1, 16'h0F0F); rows.push_back(r);
		foreach (rows[i]) send_tri(rows[i].shape, rows[i].known, rows[i].want);
		end_burst();

		set_line(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
			rnd_coord());
		random_phase(130, 1 << 20, 40);
		set_line(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
		random_phase(110, 1 << 22, -1);
		set_line(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN);
		random_phase(110, 1 << 16, -1);
		set_line(-3, 5, 0, 4, -2, 1);
		random_phase(110, 64, -1);
		set_line(100, 100, 100, 100, 100, 100);
		random_phase(40, 1 << 10, -1);
		set_line(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
			rnd_coord());
		quiet = 1;
		random_phase(140, 1 << 12, -1);

		wait (crossings_due.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
		$display("Sent %0d triangles over 8 line settings; %0d results, %0d hits.",
			tri_count, result_count, hit_count);
		$display("Covered degenerate and in-plane lines, extremes, and a long output stall.");
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
